### design/grain128aead_update_x16_defines.svh
// assertion macros for the grain-128aead sixteen-step keystream core
`ifndef GRAIN128AEAD_UPDATE_X16_DEFINES_SVH
`define GRAIN128AEAD_UPDATE_X16_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define G128_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define G128_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/g128_pkg.sv
// shared types and constants for the grain-128aead sixteen-step keystream core
`timescale 1ns / 1ps
`default_nettype none

package g128_pkg;

    // one state word, eight words per register
    localparam int WORD_W  = 16;
    localparam int NWORDS  = 8;
    localparam int REG_W   = WORD_W * NWORDS;
    localparam int IDX_W   = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [REG_W-1:0]  fsr_t;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_CLOCK = 1'b1
    } action_t;

    // feedback and pre-output bits of sixteen steps
    typedef struct packed {
        word_t lf;
        word_t nf;
        word_t y;
    } g128_fb_t;

endpackage

`default_nettype wire

### design/g128_cmd_if.sv
// valid/ready channels: command items in, pre-output words out
`timescale 1ns / 1ps
`default_nettype none

interface g128_cmd_if
    import g128_pkg::*;
;
    logic                    valid;
    logic                    ready;
    action_t                 action;
    logic [IDX_W-1:0]        word_index;
    word_t                   word_value;

    modport source (output valid, output action, output word_index, output word_value,
                    input ready);
    modport sink   (input valid, input action, input word_index, input word_value,
                    output ready);
endinterface

interface g128_rsp_if
    import g128_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t y_bits;

    modport source (output valid, output y_bits, input ready);
    modport sink   (input valid, input y_bits, output ready);
endinterface

`default_nettype wire

### design/grain128aead_update_x16.sv
// top level of the grain-128aead keystream core that advances sixteen steps per item
//
// grain-128aead keystream core, sixteen steps per transfer. the 128-bit lfsr and
// 128-bit nfsr live in flip-flops, bit 16k+j of a register being bit j of word k.
// a load transfer (action = load) writes one word: index 0-7 picks an lfsr word,
// 8-15 an nfsr word; its response carries y_bits = 0. a clock transfer computes
// sixteen pre-output bits and sixteen feedback bits for each register from the
// contents before the transfer, shifts both registers down one word and returns
// the pre-output bits, bit t for step t. every command transfer yields exactly one
// response transfer, in order. rate: one command per cycle while responses go out;
// the response sits in the output register from the cycle after its command
// transfer. the critical loop is state register -> round logic (at most a four-input
// and feeding a xor tree) -> state register. the command side keeps accepting while
// a response waits, as long as the response is taken in the same cycle; with the
// response side stalled, commands are held off. reset clears both registers to zero.
`timescale 1ns / 1ps
`default_nettype none

`include "grain128aead_update_x16_defines.svh"

module grain128aead_update_x16
    import g128_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    g128_cmd_if.sink    cmd,
    g128_rsp_if.source  rsp
);

    // feedback state
    fsr_t     lfsr_reg;
    fsr_t     lfsr_next;
    fsr_t     nfsr_reg;
    fsr_t     nfsr_next;

    // response register
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    word_t    y_bits_reg;
    word_t    y_bits_next;

    g128_fb_t fb;
    logic     cmd_xfer;
    logic     rsp_xfer;
    logic [$clog2(REG_W)-1:0] load_base;

    g128_round u_round (
        .lfsr (lfsr_reg),
        .nfsr (nfsr_reg),
        .fb   (fb)
    );

    // the output register frees up when empty or when its response goes out now
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign rsp_xfer  = rsp_valid_reg && rsp.ready;

    // bit offset of the loaded word inside its register
    assign load_base = {cmd.word_index[IDX_W-2:0], {$clog2(WORD_W){1'b0}}};

    always_comb
    begin
        lfsr_next      = lfsr_reg;
        nfsr_next      = nfsr_reg;
        y_bits_next    = y_bits_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_xfer)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd_xfer)
        begin
            rsp_valid_next = 1'b1;
            case (cmd.action)
                ACT_LOAD:
                begin
                    // top index bit selects the nfsr
                    if (cmd.word_index[IDX_W-1])
                    begin
                        nfsr_next[load_base +: WORD_W] = cmd.word_value;
                    end
                    else
                    begin
                        lfsr_next[load_base +: WORD_W] = cmd.word_value;
                    end
                    y_bits_next = '0;
                end
                ACT_CLOCK:
                begin
                    // shift down one word, feedback enters the top word
                    lfsr_next   = {fb.lf, lfsr_reg[REG_W-1:WORD_W]};
                    nfsr_next   = {fb.nf, nfsr_reg[REG_W-1:WORD_W]};
                    y_bits_next = fb.y;
                end
                default:
                begin
                    y_bits_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg      <= '0;
            nfsr_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            lfsr_reg      <= lfsr_next;
            nfsr_reg      <= nfsr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        y_bits_reg <= y_bits_next;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.y_bits = y_bits_reg;

    // a load answers with zero pre-output bits in the next cycle
    `G128_ASSERT_NEXT(a_load_rsp_zero, cmd_xfer && (cmd.action == ACT_LOAD), rsp.valid && (rsp.y_bits == '0), "load transfer did not give a zero response")

    // a clock transfer moves the top lfsr and nfsr words down by one
    `G128_ASSERT_NEXT(a_clock_shift, cmd_xfer && (cmd.action == ACT_CLOCK), (lfsr_reg[REG_W-WORD_W-1 -: WORD_W] == $past(lfsr_reg[REG_W-1 -: WORD_W])) && (nfsr_reg[REG_W-WORD_W-1 -: WORD_W] == $past(nfsr_reg[REG_W-1 -: WORD_W])), "state did not shift by one word")

    // a stalled response holds off the command side
    `G128_ASSERT_NOW(a_stall_blocks_cmd, rsp.valid && !rsp.ready, !cmd.ready, "command taken while response stalled")

    // with no command transfer, state holds
    `G128_ASSERT_NEXT(a_state_hold, !cmd_xfer, $stable(lfsr_reg) && $stable(nfsr_reg), "state changed without a command transfer")

endmodule

`default_nettype wire

### design/g128_round.sv
// sixteen parallel steps of the grain-128aead lfsr, nfsr and pre-output functions
`timescale 1ns / 1ps
`default_nettype none

module g128_round
    import g128_pkg::*;
(
    input  wire fsr_t lfsr,
    input  wire fsr_t nfsr,
    output g128_fb_t  fb
);

    // bit t of each term is the tap at time t, so a tap at i is the slice [i +: 16]
    always_comb
    begin
        fb.lf = lfsr[0 +: WORD_W] ^ lfsr[7 +: WORD_W] ^ lfsr[38 +: WORD_W]
              ^ lfsr[70 +: WORD_W] ^ lfsr[81 +: WORD_W] ^ lfsr[96 +: WORD_W];

        fb.nf = lfsr[0 +: WORD_W] ^ nfsr[0 +: WORD_W] ^ nfsr[26 +: WORD_W]
              ^ nfsr[56 +: WORD_W] ^ nfsr[91 +: WORD_W] ^ nfsr[96 +: WORD_W]
              ^ (nfsr[3 +: WORD_W] & nfsr[67 +: WORD_W])
              ^ (nfsr[11 +: WORD_W] & nfsr[13 +: WORD_W])
              ^ (nfsr[17 +: WORD_W] & nfsr[18 +: WORD_W])
              ^ (nfsr[27 +: WORD_W] & nfsr[59 +: WORD_W])
              ^ (nfsr[40 +: WORD_W] & nfsr[48 +: WORD_W])
              ^ (nfsr[61 +: WORD_W] & nfsr[65 +: WORD_W])
              ^ (nfsr[68 +: WORD_W] & nfsr[84 +: WORD_W])
              ^ (nfsr[22 +: WORD_W] & nfsr[24 +: WORD_W] & nfsr[25 +: WORD_W])
              ^ (nfsr[70 +: WORD_W] & nfsr[78 +: WORD_W] & nfsr[82 +: WORD_W])
              ^ (nfsr[88 +: WORD_W] & nfsr[92 +: WORD_W] & nfsr[93 +: WORD_W]
                 & nfsr[95 +: WORD_W]);

        fb.y  = (nfsr[12 +: WORD_W] & lfsr[8 +: WORD_W])
              ^ (lfsr[13 +: WORD_W] & lfsr[20 +: WORD_W])
              ^ (nfsr[95 +: WORD_W] & lfsr[42 +: WORD_W])
              ^ (lfsr[60 +: WORD_W] & lfsr[79 +: WORD_W])
              ^ (nfsr[12 +: WORD_W] & nfsr[95 +: WORD_W] & lfsr[94 +: WORD_W])
              ^ lfsr[93 +: WORD_W]
              ^ nfsr[2 +: WORD_W] ^ nfsr[15 +: WORD_W] ^ nfsr[36 +: WORD_W]
              ^ nfsr[45 +: WORD_W] ^ nfsr[64 +: WORD_W] ^ nfsr[73 +: WORD_W]
              ^ nfsr[89 +: WORD_W];
    end

endmodule

`default_nettype wire
